// ===== design/rbd_pkg.sv =====
// Shared types, register codes and arithmetic helpers for the raw block decompressor.
// No dependencies; every other design file imports this package.
package rbd_pkg;

   localparam int NUM_LANES    = 2;
   localparam int NUM_SLOTS    = 4;
   localparam int NUM_PIXELS   = NUM_LANES * NUM_SLOTS;
   localparam int Q_W          = 10;
   localparam int PIX_W        = 16;
   localparam int CSR_INDEX_W  = 4;
   localparam int CSR_DATA_W   = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_COMPRESS_MODE = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BLACK_OFFSET  = 4'd1;

   localparam logic [1:0]       COMPRESS_MODE_RESET = 2'd1;
   localparam logic [PIX_W-1:0] BLACK_OFFSET_RESET  = 16'd2048;

   // compress_mode decoding
   localparam int         CMODE_EXP_BIT  = 1;
   localparam logic [1:0] CMODE_EXP_FINE = 2'd3;

   // per-word quantisation modes
   localparam logic [1:0] QMODE_FINE   = 2'd0;
   localparam logic [1:0] QMODE_MID    = 2'd1;
   localparam logic [1:0] QMODE_COARSE = 2'd2;
   localparam logic [1:0] QMODE_PACKED = 2'd3;

   // floor(n / 11) == (n * 187) >> 11 for all 7-bit n
   localparam logic [14:0] DIV11_MULT = 15'd187;

   typedef struct packed {
      logic [31:0] word_even;
      logic [31:0] word_odd;
   } req_word_type;

   typedef struct packed {
      logic [PIX_W-1:0] pixel_0;
      logic [PIX_W-1:0] pixel_1;
      logic [PIX_W-1:0] pixel_2;
      logic [PIX_W-1:0] pixel_3;
      logic [PIX_W-1:0] pixel_4;
      logic [PIX_W-1:0] pixel_5;
      logic [PIX_W-1:0] pixel_6;
      logic [PIX_W-1:0] pixel_7;
   } rsp_word_type;

   typedef struct packed {
      logic [1:0]                      qmode;
      logic [NUM_SLOTS-1:0][Q_W-1:0]   q;
   } lane_q_type;

   typedef struct packed {
      logic s1_en;
      logic s2_en;
      logic s3_en;
   } pipe_ctrl_type;

   function automatic logic [3:0] div11(input logic [6:0] n);
      logic [14:0] prod;
      prod = 15'(n) * DIV11_MULT;
      return prod[14:11];
   endfunction

   function automatic logic [PIX_W-1:0] dequant(input logic [Q_W-1:0] q,
                                               input logic [1:0] qmode);
      logic [19:0] v;
      case (qmode)
         QMODE_FINE: begin
            v = (q < 10'd320) ? {6'd0, q, 4'd0} : {5'd0, 10'(q - 10'd160), 5'd0};
         end
         QMODE_MID: begin
            v = {4'd0, q, 6'd0};
         end
         QMODE_COARSE: begin
            v = {3'd0, q, 7'd0};
         end
         default: begin
            v = (q < 10'd94) ? {2'd0, q, 8'd0} : {1'd0, 10'(q - 10'd47), 9'd0};
         end
      endcase
      return (v > 20'd65535) ? 16'hFFFF : v[15:0];
   endfunction

   function automatic logic [PIX_W-1:0] expand(input logic [PIX_W-1:0] a,
                                              input logic [1:0] cmode,
                                              input logic [PIX_W-1:0] off);
      logic [PIX_W-1:0] e;
      logic [PIX_W:0]   s;
      e = a;
      if (cmode[CMODE_EXP_BIT]) begin
         if (cmode == CMODE_EXP_FINE && a < 16'h4000) begin
            e = a >> 2;
         end else if (a < 16'h1000) begin
            e = a >> 4;
         end else if (a < 16'h1800) begin
            e = 16'(a - 16'h0800) >> 3;
         end else if (a < 16'h3000) begin
            e = 16'(a - 16'h1000) >> 2;
         end else if (a < 16'h6000) begin
            e = 16'(a - 16'h2000) >> 1;
         end else if (a < 16'hC000) begin
            e = 16'(a - 16'h4000);
         end else begin
            e = 16'(a - 16'h8000) << 1;
         end
      end
      s = {1'b0, e} + {1'b0, off};
      return s[PIX_W] ? 16'hFFFF : s[PIX_W-1:0];
   endfunction

endpackage

// ===== design/raw_block_decompressor.sv =====
// Top level: two word lanes, eight pixel lanes, merge into the response word, CSRs.
// Depends on rbd_pkg, rbd_word_lane and rbd_pixel_lane.
//
//  port group | dir | handshake          | payload
//  req_       | in  | req_valid/req_stall| req_word  (word_even, word_odd)
//  rsp_       | out | rsp_valid/rsp_stall| rsp_word  (pixel_0 .. pixel_7)
//  csr_       | in  | csr_valid/csr_ready| csr_index, csr_wdata
//
// One word per cycle sustained while rsp_stall is low; stages: code split, dequant, expand+offset.
// Each stage holds one word; a stage loads whenever it is empty or the next one moves.
// rsp_stall reaches req_stall combinationally through the stage chain.
// Synchronous reset empties the pipe and restores compress_mode=1, black_offset=2048.
// csr_ready is always high; registers should only be written while the pipe is empty.
module raw_block_decompressor import rbd_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  req_word_type           req_word,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_word_type           rsp_word,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   logic             s1_valid_ff, s1_valid_in;
   logic             s2_valid_ff, s2_valid_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [1:0]       mode_ff, mode_in;
   logic [PIX_W-1:0] offset_ff, offset_in;
   logic             s1_adv, s2_adv, s3_adv;
   pipe_ctrl_type    ctrl;

   logic [NUM_LANES-1:0][31:0]     lane_word;
   lane_q_type [NUM_LANES-1:0]     lane_q;
   logic [NUM_PIXELS-1:0][PIX_W-1:0] pix;

   assign s3_adv = !rsp_valid_ff || !rsp_stall;
   assign s2_adv = !s2_valid_ff || s3_adv;
   assign s1_adv = !s1_valid_ff || s2_adv;

   assign ctrl.s1_en = req_valid && s1_adv;
   assign ctrl.s2_en = s1_valid_ff && s2_adv;
   assign ctrl.s3_en = s2_valid_ff && s3_adv;

   assign s1_valid_in  = s1_adv ? req_valid : s1_valid_ff;
   assign s2_valid_in  = s2_adv ? s1_valid_ff : s2_valid_ff;
   assign rsp_valid_in = s3_adv ? s2_valid_ff : rsp_valid_ff;

   assign req_stall = !s1_adv;
   assign rsp_valid = rsp_valid_ff;
   assign csr_ready = 1'b1;

   always_comb begin
      mode_in   = mode_ff;
      offset_in = offset_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_COMPRESS_MODE: mode_in   = csr_wdata[1:0];
            CSR_BLACK_OFFSET:  offset_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         mode_ff      <= COMPRESS_MODE_RESET;
         offset_ff    <= BLACK_OFFSET_RESET;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         mode_ff      <= mode_in;
         offset_ff    <= offset_in;
      end
   end

   assign lane_word[0] = req_word.word_even;
   assign lane_word[1] = req_word.word_odd;

   for (genvar l = 0; l < NUM_LANES; l++) begin : g_word
      rbd_word_lane u_word (
         .clock  (clock),
         .ctrl   (ctrl),
         .word   (lane_word[l]),
         .lane_q (lane_q[l])
      );
   end

   // pixel p comes from lane p%2, slot p/2
   for (genvar p = 0; p < NUM_PIXELS; p++) begin : g_pix
      rbd_pixel_lane u_pix (
         .clock         (clock),
         .ctrl          (ctrl),
         .q             (lane_q[p % NUM_LANES].q[p / NUM_LANES]),
         .qmode         (lane_q[p % NUM_LANES].qmode),
         .compress_mode (mode_ff),
         .black_offset  (offset_ff),
         .pixel         (pix[p])
      );
   end

   assign rsp_word.pixel_0 = pix[0];
   assign rsp_word.pixel_1 = pix[1];
   assign rsp_word.pixel_2 = pix[2];
   assign rsp_word.pixel_3 = pix[3];
   assign rsp_word.pixel_4 = pix[4];
   assign rsp_word.pixel_5 = pix[5];
   assign rsp_word.pixel_6 = pix[6];
   assign rsp_word.pixel_7 = pix[7];

   a_accept_fills_s1: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> s1_valid_ff)
      else $error("accepted word did not reach stage 1");

   a_s2_held: assert property (@(posedge clock) disable iff (reset)
      s2_valid_ff && !ctrl.s3_en |=> s2_valid_ff)
      else $error("stage 2 word dropped while output blocked");

   a_no_bubble_stall: assert property (@(posedge clock) disable iff (reset)
      !rsp_stall |-> !req_stall)
      else $error("input stalled while output is free");

   a_csr_mode: assert property (@(posedge clock) disable iff (reset)
      csr_valid && csr_ready && csr_index == CSR_COMPRESS_MODE
      |=> mode_ff == $past(csr_wdata[1:0]))
      else $error("compress_mode write lost");

endmodule

// ===== design/rbd_word_lane.sv =====
// One word lane: splits a 32-bit word into its mode and four quantised codes, registered.
// Depends on rbd_pkg.
module rbd_word_lane import rbd_pkg::*; (
   input  logic          clock,
   input  pipe_ctrl_type ctrl,
   input  logic [31:0]   word,
   output lane_q_type    lane_q
);

   lane_q_type  q_ff;
   lane_q_type  q_in;

   logic [8:0]  base;
   logic [6:0]  delta;
   logic [6:0]  r0;
   logic [6:0]  r1;
   logic [9:0]  q1;
   logic [9:0]  q2;
   logic [9:0]  p1;
   logic [9:0]  p2;
   logic [14:0] k0;
   logic [14:0] k1;
   logic [3:0]  quo0;
   logic [3:0]  quo1;
   logic [1:0]  qmode;

   always_comb begin
      qmode = word[1:0];
      base  = word[10:2];
      delta = word[17:11];
      r0    = word[24:18];
      r1    = word[31:25];
      k0    = word[16:2];
      k1    = word[31:17];
      quo0  = div11(k0[14:8]);
      quo1  = div11(k1[14:8]);

      if (qmode == QMODE_COARSE && base >= 9'd384) begin
         q1 = {1'b0, base};
         q2 = 10'(delta) + 10'd384;
      end else if (delta >= 7'd64) begin
         q1 = {1'b0, base};
         q2 = 10'(base) + 10'(delta) - 10'd64;
      end else begin
         q1 = 10'(base) + 10'd64 - 10'(delta);
         q2 = {1'b0, base};
      end
      p1 = (q1 > 10'd64) ? 10'(q1 - 10'd64) : 10'd0;
      p2 = (q2 > 10'd64) ? 10'(q2 - 10'd64) : 10'd0;
      if (qmode == QMODE_COARSE) begin
         if (p1 > 10'd384) p1 = 10'd384;
         if (p2 > 10'd384) p2 = 10'd384;
      end

      q_in.qmode = qmode;
      if (qmode == QMODE_PACKED) begin
         q_in.q[0] = 10'(k0[3:0]) + {2'd0, quo0, 4'd0};
         q_in.q[1] = 10'(11'(k0[14:4]) - 11'(quo0) * 11'd176);
         q_in.q[2] = 10'(k1[3:0]) + {2'd0, quo1, 4'd0};
         q_in.q[3] = 10'(11'(k1[14:4]) - 11'(quo1) * 11'd176);
      end else begin
         q_in.q[0] = p1 + 10'(r0);
         q_in.q[1] = q1;
         q_in.q[2] = q2;
         q_in.q[3] = p2 + 10'(r1);
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.s1_en) begin
         q_ff <= q_in;
      end
   end

   assign lane_q = q_ff;

endmodule

// ===== design/rbd_pixel_lane.sv =====
// One pixel lane: dequantises a code, then applies expansion and black offset.
// Two register stages; depends on rbd_pkg.
module rbd_pixel_lane import rbd_pkg::*; (
   input  logic             clock,
   input  pipe_ctrl_type    ctrl,
   input  logic [Q_W-1:0]   q,
   input  logic [1:0]       qmode,
   input  logic [1:0]       compress_mode,
   input  logic [PIX_W-1:0] black_offset,
   output logic [PIX_W-1:0] pixel
);

   logic [PIX_W-1:0] deq_ff;
   logic [PIX_W-1:0] deq_in;
   logic [PIX_W-1:0] pix_ff;
   logic [PIX_W-1:0] pix_in;

   assign deq_in = dequant(q, qmode);
   assign pix_in = expand(deq_ff, compress_mode, black_offset);

   always_ff @(posedge clock) begin
      if (ctrl.s2_en) begin
         deq_ff <= deq_in;
      end
      if (ctrl.s3_en) begin
         pix_ff <= pix_in;
      end
   end

   assign pixel = pix_ff;

endmodule
